[hdl/ked_pkg.sv]
// Shared constants and types for the key escape decoder with cursor.
package ked_pkg;

	localparam int MAX_DIM = 1023;

	localparam logic [9:0] COLS_RESET = 10'd80;
	localparam logic [9:0] ROWS_RESET = 10'd24;

	localparam logic [0:0] REG_COLS = 1'b0;
	localparam logic [0:0] REG_ROWS = 1'b1;

	localparam logic [7:0] B_ESC   = 8'h1b;
	localparam logic [7:0] B_LBRK  = 8'h5b;
	localparam logic [7:0] B_SS3   = 8'h4f;
	localparam logic [7:0] B_TILDE = 8'h7e;
	localparam logic [7:0] B_CTRLQ = 8'h11;

	localparam logic [8:0] K_ESC   = 9'h01b;
	localparam logic [8:0] K_CTRLQ = 9'h011;
	localparam logic [8:0] K_LEFT  = 9'd256;
	localparam logic [8:0] K_RIGHT = 9'd257;
	localparam logic [8:0] K_UP    = 9'd258;
	localparam logic [8:0] K_DOWN  = 9'd259;
	localparam logic [8:0] K_DEL   = 9'd260;
	localparam logic [8:0] K_HOME  = 9'd261;
	localparam logic [8:0] K_END   = 9'd262;
	localparam logic [8:0] K_PGUP  = 9'd263;
	localparam logic [8:0] K_PGDN  = 9'd264;

	typedef enum logic [1:0] {
		PC_OTHER = 2'd0,
		PC_CSI   = 2'd1,
		PC_SS3   = 2'd2
	} prefix_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_ESC    = 4'b0010,
		PH_PREFIX = 4'b0100,
		PH_DIGIT  = 4'b1000
	} phase_t;

endpackage

[hdl/key_escape_decoder_cursor_unit.sv]
// Top level: VT100 key sequence decoder driving a clamped text cursor.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata = data_byte, s_tuser = kind (1 = timeout)
// m_*       out  m_tvalid/m_tready  m_tdata = key_code,col,row, m_tuser = quit
// cfg_*     in   cfg_we             cfg_index selects cols/rows, cfg_data value
//
// One request per cycle while the output is not stalled; a key is built from its last
// byte by the input register, decode and cursor logic, then the output register.
// Reset: parser idle, cursor at 0,0, screen 80 x 24.
// A stalled output holds the input stage; the input stays ready while the
// output is empty, being taken, or the staged byte produces no key.
module key_escape_decoder_cursor_unit #(
	parameter int MAX_DIM = ked_pkg::MAX_DIM
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [8:0] key_code, [18:9] cursor_col, [28:19] cursor_row
	output logic        m_tuser,   // [0] quit
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	logic [9:0] cols_q, rows_q;
	logic       v_s1, kind_s1;
	logic [7:0] byte_s1;
	ked_pkg::phase_t  phase_q, phase_d;
	ked_pkg::prefix_t prefix_q, prefix_d;
	logic [7:0] digit_q, digit_d;
	logic [9:0] col_q, row_q;
	logic       v_s2, quit_s2;
	logic [8:0] key_s2;
	logic [9:0] col_s2, row_s2;

	logic       emit, advance;
	logic [8:0] key;
	logic [9:0] cols_e, rows_e, cols_m1, rows_m1, col_c, row_c, col_n, row_n;

	assign advance  = v_s1 && (!v_s2 || m_tready || !emit);
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ked_pkg::COLS_RESET;
			rows_q <= ked_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ked_pkg::REG_COLS: cols_q <= cfg_data;
				ked_pkg::REG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// parser
	always_comb begin
		phase_d  = ked_pkg::PH_IDLE;
		prefix_d = prefix_q;
		digit_d  = digit_q;
		emit     = 1'b0;
		key      = ked_pkg::K_ESC;
		unique case (phase_q)
			ked_pkg::PH_ESC: begin
				if (kind_s1) begin
					emit = 1'b1;
				end else begin
					phase_d  = ked_pkg::PH_PREFIX;
					prefix_d = (byte_s1 == ked_pkg::B_LBRK) ? ked_pkg::PC_CSI :
					           (byte_s1 == ked_pkg::B_SS3)  ? ked_pkg::PC_SS3 :
					                                          ked_pkg::PC_OTHER;
				end
			end
			ked_pkg::PH_PREFIX: begin
				if (kind_s1) begin
					emit = 1'b1;
				end else if (prefix_q == ked_pkg::PC_CSI &&
				             byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
					phase_d = ked_pkg::PH_DIGIT;
					digit_d = byte_s1;
				end else begin
					emit = 1'b1;
					if (prefix_q == ked_pkg::PC_CSI) begin
						unique case (byte_s1)
							8'h41: key = ked_pkg::K_UP;
							8'h42: key = ked_pkg::K_DOWN;
							8'h43: key = ked_pkg::K_RIGHT;
							8'h44: key = ked_pkg::K_LEFT;
							8'h48: key = ked_pkg::K_HOME;
							8'h46: key = ked_pkg::K_END;
							default: key = ked_pkg::K_ESC;
						endcase
					end else if (prefix_q == ked_pkg::PC_SS3) begin
						unique case (byte_s1)
							8'h48: key = ked_pkg::K_HOME;
							8'h46: key = ked_pkg::K_END;
							default: key = ked_pkg::K_ESC;
						endcase
					end
				end
			end
			ked_pkg::PH_DIGIT: begin
				emit = 1'b1;
				if (!kind_s1 && byte_s1 == ked_pkg::B_TILDE) begin
					unique case (digit_q) inside
						8'h31, 8'h37: key = ked_pkg::K_HOME;
						8'h33:        key = ked_pkg::K_DEL;
						8'h34, 8'h38: key = ked_pkg::K_END;
						8'h35:        key = ked_pkg::K_PGUP;
						8'h36:        key = ked_pkg::K_PGDN;
						default:      key = ked_pkg::K_ESC;
					endcase
				end
			end
			default: begin
				if (!kind_s1) begin
					if (byte_s1 == ked_pkg::B_ESC) begin
						phase_d = ked_pkg::PH_ESC;
					end else begin
						emit = 1'b1;
						key  = {1'b0, byte_s1};
					end
				end
			end
		endcase
	end

	// cursor
	always_comb begin
		if (cols_q == 10'd0)             cols_e = 10'd1;
		else if (int'(cols_q) > MAX_DIM) cols_e = 10'(MAX_DIM);
		else                             cols_e = cols_q;
		if (rows_q == 10'd0)             rows_e = 10'd1;
		else if (int'(rows_q) > MAX_DIM) rows_e = 10'(MAX_DIM);
		else                             rows_e = rows_q;
		cols_m1 = cols_e - 10'd1;
		rows_m1 = rows_e - 10'd1;
		col_c   = (col_q > cols_m1) ? cols_m1 : col_q;
		row_c   = (row_q > rows_m1) ? rows_m1 : row_q;
		col_n   = col_c;
		row_n   = row_c;
		case (key)
			ked_pkg::K_LEFT:  if (col_c != 10'd0)   col_n = col_c - 10'd1;
			ked_pkg::K_RIGHT: if (col_c != cols_m1) col_n = col_c + 10'd1;
			ked_pkg::K_UP:    if (row_c != 10'd0)   row_n = row_c - 10'd1;
			ked_pkg::K_DOWN:  if (row_c != rows_m1) row_n = row_c + 10'd1;
			ked_pkg::K_HOME:  col_n = 10'd0;
			ked_pkg::K_END:   col_n = cols_m1;
			ked_pkg::K_PGUP:  row_n = 10'd0;
			ked_pkg::K_PGDN:  row_n = rows_m1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ked_pkg::PH_IDLE;
			prefix_q <= ked_pkg::PC_OTHER;
			digit_q  <= 8'd0;
			col_q    <= 10'd0;
			row_q    <= 10'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			prefix_q <= prefix_d;
			digit_q  <= digit_d;
			if (emit) begin
				col_q <= col_n;
				row_q <= row_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance && emit) begin
			v_s2 <= 1'b1;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			key_s2  <= key;
			col_s2  <= col_n;
			row_s2  <= row_n;
			quit_s2 <= (key == ked_pkg::K_CTRLQ);
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {3'b000, row_s2, col_s2, key_s2};
	assign m_tuser  = quit_s2;

endmodule
